FILE: rtl/ghbp_pkg.sv
`timescale 1ns / 1ps

package ghbp_pkg;

    // Table geometry
    localparam int HISTORY_BITS  = 4;
    localparam int PC_INDEX_BITS = 4;
    localparam int SLOT_BITS     = HISTORY_BITS + PC_INDEX_BITS;
    localparam int TABLE_DEPTH   = 1 << SLOT_BITS;

    // Width of the history carried on the ports
    localparam int SNAP_BITS = 4;

    // Beat widths
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 8;

    // Counter codes
    localparam logic [1:0] CNT_MIN   = 2'd0;
    localparam logic [1:0] CNT_RESET = 2'd1;
    localparam logic [1:0] CNT_MAX   = 2'd3;

    // Item kinds
    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_UPDATE  = 1'b1;

    typedef logic [HISTORY_BITS-1:0] hist_t;
    typedef logic [SLOT_BITS-1:0]    slot_t;
    typedef logic [SNAP_BITS-1:0]    snap_t;

    // Output beat payload
    typedef struct packed {
        snap_t history_snapshot;
        logic  predicted_taken;
    } result_t;

    // Row = (history ^ pc>>2) low bits, column = (pc>>2) low bits
    function automatic slot_t table_slot(hist_t hist, logic [31:0] pc);
        hist_t                    row;
        logic [PC_INDEX_BITS-1:0] col;
        row = hist ^ pc[2 +: HISTORY_BITS];
        col = pc[2 +: PC_INDEX_BITS];
        return {row, col};
    endfunction

    // Saved history from the port, zero-extended or cut to the table history
    function automatic hist_t hist_from_snap(snap_t snap);
        logic [HISTORY_BITS+SNAP_BITS-1:0] wide;
        wide = {{HISTORY_BITS{1'b0}}, snap};
        return wide[HISTORY_BITS-1:0];
    endfunction

    // Live history to port width
    function automatic snap_t snap_from_hist(hist_t hist);
        logic [HISTORY_BITS+SNAP_BITS-1:0] wide;
        wide = {{SNAP_BITS{1'b0}}, hist};
        return wide[SNAP_BITS-1:0];
    endfunction

endpackage

FILE: rtl/ghbp_ram.sv
`timescale 1ns / 1ps

module ghbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (read returns old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/global_history_branch_predictor_unit.sv
`timescale 1ns / 1ps
// A result beat passes through the stage 1 registers and then the output queue.
// Throughput: one item per cycle while the output queue has room; each item is one
// counter-table read-modify-write through a single-port-read memory, with the last
// write forwarded to the next read. Reset: history clears to zero; 256 entry valid
// bits clear at once; an entry never written reads weakly not taken; no beat pending.

module global_history_branch_predictor_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pc[31:0], taken[32], saved_history[36:33], zero fill
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // predicted_taken[0], history_snapshot[4:1], zero fill
);

    import ghbp_pkg::*;

    // Input unpack
    logic        in_accept;
    logic        in_mode;
    logic [31:0] in_pc;
    logic        in_taken;
    snap_t       in_saved;

    assign in_mode   = s_tuser;
    assign in_pc     = s_tdata[31:0];
    assign in_taken  = s_tdata[32];
    assign in_saved  = s_tdata[33 +: SNAP_BITS];
    assign in_accept = s_tvalid && s_tready;

    // Live global history
    hist_t hist_reg;
    hist_t hist_next;
    logic [HISTORY_BITS:0] hist_shift;

    assign hist_shift = {hist_reg, in_taken};

    always_comb
    begin
        hist_next = hist_reg;
        if (in_accept && in_mode == MODE_UPDATE)
        begin
            hist_next = hist_shift[HISTORY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

    // Read address
    slot_t rd_slot;
    assign rd_slot = (in_mode == MODE_UPDATE) ? table_slot(hist_from_snap(in_saved), in_pc)
                                              : table_slot(hist_reg, in_pc);

    // Stage 1 registers
    logic  s1_valid_reg;
    logic  s1_mode_reg;
    logic  s1_taken_reg;
    slot_t s1_slot_reg;
    snap_t s1_snap_reg;
    logic  s1_rvalid_reg;

    // Last committed write, for forwarding
    logic       wr_en_reg;
    slot_t      wr_slot_reg;
    logic [1:0] wr_data_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;

    // Counter memory
    logic       ram_we;
    logic [1:0] ram_rdata;
    logic [1:0] cnt_cur;
    logic [1:0] cnt_new;

    ghbp_ram #(
        .WIDTH (2),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_slot_reg),
        .wdata (cnt_new),
        .raddr (rd_slot),
        .rdata (ram_rdata)
    );

    // Current counter: forward the previous write, else memory, else reset value
    always_comb
    begin
        if (wr_en_reg && wr_slot_reg == s1_slot_reg)
        begin
            cnt_cur = wr_data_reg;
        end
        else if (s1_rvalid_reg)
        begin
            cnt_cur = ram_rdata;
        end
        else
        begin
            cnt_cur = CNT_RESET;
        end
    end

    // Saturating step toward the outcome
    always_comb
    begin
        cnt_new = cnt_cur;
        if (s1_taken_reg)
        begin
            if (cnt_cur != CNT_MAX)
            begin
                cnt_new = cnt_cur + 2'd1;
            end
        end
        else
        begin
            if (cnt_cur != CNT_MIN)
            begin
                cnt_new = cnt_cur - 2'd1;
            end
        end
    end

    assign ram_we = s1_valid_reg && s1_mode_reg == MODE_UPDATE;

    // Stage 1 result
    result_t s1_result;
    assign s1_result.predicted_taken  = (s1_mode_reg == MODE_PREDICT) ? cnt_cur[1] : 1'b0;
    assign s1_result.history_snapshot = s1_snap_reg;

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_en_reg    <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            wr_en_reg    <= ram_we;
            if (ram_we)
            begin
                valid_reg[s1_slot_reg] <= 1'b1;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg   <= in_mode;
            s1_taken_reg  <= in_taken;
            s1_slot_reg   <= rd_slot;
            s1_snap_reg   <= snap_from_hist(hist_reg);
            s1_rvalid_reg <= valid_reg[rd_slot];
        end
        if (ram_we)
        begin
            wr_slot_reg <= s1_slot_reg;
            wr_data_reg <= cnt_new;
        end
    end

    // Two-entry output queue
    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    ent0_reg;
    result_t    ent1_reg;
    logic       out_push;
    logic       out_pop;

    assign out_push = s1_valid_reg;
    assign out_pop  = m_tvalid && m_tready;
    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = {3'b000, ent0_reg};

    // Take a beat only if it will find room when it leaves stage 1
    assign s_tready = ({1'b0, count_reg} + {2'b00, s1_valid_reg} - {2'b00, out_pop}) < 3'd2;

    assign count_next = count_reg + {1'b0, out_push} - {1'b0, out_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_pop)
        begin
            if (count_reg == 2'd2)
            begin
                ent0_reg <= ent1_reg;
                if (out_push)
                begin
                    ent1_reg <= s1_result;
                end
            end
            else if (out_push)
            begin
                ent0_reg <= s1_result;
            end
        end
        else if (out_push)
        begin
            if (count_reg == 2'd0)
            begin
                ent0_reg <= s1_result;
            end
            else
            begin
                ent1_reg <= s1_result;
            end
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (count_reg < 2'd2 || out_pop))
        else $error("output queue overflow");

    a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en_reg |-> valid_reg[wr_slot_reg])
        else $error("written entry not marked valid");

    a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_mode == MODE_UPDATE) |=> hist_reg[0] == $past(in_taken))
        else $error("history did not take the outcome");

    a_update_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !s1_result.predicted_taken)
        else $error("update item reported taken");

endmodule
